// File: design/assert_macros.svh
// Assertion macros shared by the predecoder checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, masked while reset is asserted
`define R16PD_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Same-cycle implication
`define R16PD_ASSERT_IMP(label, ante, cons, msg) \
	`R16PD_ASSERT(label, (ante) |-> (cons), msg)

// Next-cycle implication
`define R16PD_ASSERT_NXT(label, ante, cons, msg) \
	`R16PD_ASSERT(label, (ante) |=> (cons), msg)

`endif

// File: design/r16pd_pkg.sv
// Package with types, codes and decode helpers of the 16-bit instruction predecoder.
`default_nettype none

package r16pd_pkg;

	localparam logic [15:0] BASE_RESET = 16'hC000;

	typedef enum logic [2:0] {
		KIND_ZERO   = 3'd0,
		KIND_ALIAS  = 3'd1,
		KIND_SINGLE = 3'd2,
		KIND_JUMP   = 3'd3,
		KIND_DOUBLE = 3'd4,
		KIND_DATA   = 3'd5,
		KIND_EXT    = 3'd6,
		KIND_REJECT = 3'd7
	} kind_t;

	// Mnemonic ids
	localparam logic [5:0] ID_JUMP0  = 6'd7;
	localparam logic [5:0] ID_DBL0   = 6'd11;
	localparam logic [5:0] ID_POP    = 6'd27;
	localparam logic [5:0] ID_BR     = 6'd28;
	localparam logic [5:0] ID_INC    = 6'd29;
	localparam logic [5:0] ID_INCD   = 6'd30;
	localparam logic [5:0] ID_RLA    = 6'd31;
	localparam logic [5:0] ID_ADC    = 6'd32;
	localparam logic [5:0] ID_RLC    = 6'd33;
	localparam logic [5:0] ID_SBC    = 6'd34;
	localparam logic [5:0] ID_DEC    = 6'd35;
	localparam logic [5:0] ID_DECD   = 6'd36;
	localparam logic [5:0] ID_TST    = 6'd37;
	localparam logic [5:0] ID_DADC   = 6'd38;
	localparam logic [5:0] ID_INV    = 6'd39;
	localparam logic [5:0] ID_ALIAS0 = 6'd40;

	// Opcodes of the two-operand group
	localparam logic [3:0] OP_MOV  = 4'd4;
	localparam logic [3:0] OP_ADD  = 4'd5;
	localparam logic [3:0] OP_ADDC = 4'd6;
	localparam logic [3:0] OP_SUBC = 4'd7;
	localparam logic [3:0] OP_SUB  = 4'd8;
	localparam logic [3:0] OP_CMP  = 4'd9;
	localparam logic [3:0] OP_DADD = 4'd10;
	localparam logic [3:0] OP_XOR  = 4'd14;

	// Single-operand opcodes with special handling
	localparam logic [2:0] SOP_RETI    = 3'd6;
	localparam logic [2:0] SOP_INVALID = 3'd7;

	localparam int unsigned ALIAS_COUNT = 10;
	localparam logic [15:0] ALIAS_WORDS [ALIAS_COUNT] = '{
		16'h4303, 16'hC232, 16'hD232, 16'hC312, 16'hC222,
		16'hC322, 16'hD312, 16'hD222, 16'hD322, 16'h4130
	};

	typedef struct packed {
		logic [15:0] word_address;
		kind_t       word_kind;
		logic [5:0]  mnemonic_id;
		logic        byte_flag;
		logic [3:0]  source_register;
		logic [1:0]  source_mode;
		logic [3:0]  dest_register;
		logic [1:0]  dest_mode;
		logic [1:0]  extension_count;
		logic [15:0] jump_target;
		logic [15:0] passed_word;
	} result_t;

	// One extension word for indexed, absolute, symbolic and immediate operands
	function automatic logic ext_needed(input logic [3:0] rg, input logic [1:0] md);
		logic need;
		if (rg == 4'd3)
			need = 1'b0;
		else if (rg == 4'd0)
			need = (md == 2'd1) || (md == 2'd3);
		else
			need = (md == 2'd1);
		return need;
	endfunction

	// Mnemonic of a two-operand word, emulated forms included
	function automatic logic [5:0] double_id(input logic [3:0] op, input logic [3:0] sr,
			input logic [1:0] sm, input logic [3:0] dr, input logic dm);
		logic       c3;
		logic       same;
		logic [5:0] id;
		c3   = (sr == 4'd3);
		same = (sr == dr) && (sm == {1'b0, dm});
		id   = ID_DBL0 + {2'b00, op};
		case (op)
			OP_MOV: begin
				if (sr == 4'd1 && sm == 2'd3) id = ID_POP;
				else if (dr == 4'd0) id = ID_BR;
			end
			OP_ADD: begin
				if (c3) begin
					if (sm == 2'd1) id = ID_INC;
					else if (sm == 2'd2) id = ID_INCD;
				end else if (same) begin
					id = ID_RLA;
				end
			end
			OP_ADDC: begin
				if (c3 && sm == 2'd0) id = ID_ADC;
				else if (same) id = ID_RLC;
			end
			OP_SUBC: begin
				if (c3 && sm == 2'd0) id = ID_SBC;
			end
			OP_SUB: begin
				if (c3 && sm == 2'd1) id = ID_DEC;
				else if (c3 && sm == 2'd2) id = ID_DECD;
			end
			OP_CMP: begin
				if (c3 && sm == 2'd0) id = ID_TST;
			end
			OP_DADD: begin
				if (c3 && sm == 2'd0) id = ID_DADC;
			end
			OP_XOR: begin
				if (c3 && sm == 2'd3) id = ID_INV;
			end
			default: begin
				id = ID_DBL0 + {2'b00, op};
			end
		endcase
		return id;
	endfunction

endpackage

`default_nettype wire

// File: design/r16pd_if.sv
// Valid/ready channel interfaces for code words and decode results.
`default_nettype none

interface r16pd_code_if;
	logic        valid;
	logic        ready;
	logic [15:0] code_word;
	logic        image_start;

	modport source (output valid, output code_word, output image_start, input ready);
	modport sink (input valid, input code_word, input image_start, output ready);
endinterface

interface r16pd_result_if;
	logic        valid;
	logic        ready;
	logic [15:0] word_address;
	logic [2:0]  word_kind;
	logic [5:0]  mnemonic_id;
	logic        byte_flag;
	logic [3:0]  source_register;
	logic [1:0]  source_mode;
	logic [3:0]  dest_register;
	logic [1:0]  dest_mode;
	logic [1:0]  extension_count;
	logic [15:0] jump_target;
	logic [15:0] passed_word;

	modport source (output valid, output word_address, output word_kind, output mnemonic_id,
		output byte_flag, output source_register, output source_mode, output dest_register,
		output dest_mode, output extension_count, output jump_target, output passed_word,
		input ready);
	modport sink (input valid, input word_address, input word_kind, input mnemonic_id,
		input byte_flag, input source_register, input source_mode, input dest_register,
		input dest_mode, input extension_count, input jump_target, input passed_word,
		output ready);
endinterface

`default_nettype wire

// File: design/r16pd_decode.sv
// Combinational classify and field decode of one code word.
`default_nettype none

module r16pd_decode (
	input  wire logic [15:0]       word,
	input  wire logic              image_start,
	input  wire logic [15:0]       base_address,
	input  wire logic [15:0]       cur_address,
	input  wire logic [1:0]        cur_pending,
	output r16pd_pkg::result_t     result,
	output logic [1:0]             next_pending
);

	logic [15:0] addr;
	logic [1:0]  pend;
	logic        is_single;
	logic        is_jump;
	logic        is_double;
	logic        alias_hit;
	logic [3:0]  alias_idx;
	logic [2:0]  sop;
	logic        s_ext;
	logic        d_ext;
	logic [15:0] jump_disp;

	// Restart the image where requested
	assign addr = image_start ? base_address : cur_address;
	assign pend = image_start ? 2'd0 : cur_pending;

	assign is_single = (word[15:10] == 6'b000100);
	assign is_jump   = (word[15:13] == 3'b001);
	assign is_double = (word[15:14] != 2'b00);
	assign sop       = word[9:7];
	assign jump_disp = {{5{word[9]}}, word[9:0], 1'b0};

	// Match the whole-word aliases
	always_comb begin
		alias_hit = 1'b0;
		alias_idx = 4'd0;
		for (int i = 0; i < r16pd_pkg::ALIAS_COUNT; i++) begin
			if (word == r16pd_pkg::ALIAS_WORDS[i]) begin
				alias_hit = 1'b1;
				alias_idx = 4'(i);
			end
		end
	end

	// Classify the word and pick its fields
	always_comb begin
		result              = '0;
		result.word_address = addr;
		result.passed_word  = word;
		result.word_kind    = r16pd_pkg::KIND_DATA;
		next_pending        = 2'd0;
		s_ext               = 1'b0;
		d_ext               = 1'b0;
		if (pend != 2'd0) begin
			result.word_kind = r16pd_pkg::KIND_EXT;
			next_pending     = pend - 2'd1;
		end else if (word == 16'd0) begin
			result.word_kind = r16pd_pkg::KIND_ZERO;
		end else if (is_single) begin
			result.byte_flag     = word[6];
			result.dest_mode     = word[5:4];
			result.dest_register = word[3:0];
			d_ext                = r16pd_pkg::ext_needed(word[3:0], word[5:4]);
			result.extension_count = {1'b0, d_ext};
			next_pending         = {1'b0, d_ext};
			if (sop == r16pd_pkg::SOP_INVALID
					|| (word[6] && (sop[0] || sop == r16pd_pkg::SOP_RETI))) begin
				result.word_kind = r16pd_pkg::KIND_REJECT;
			end else begin
				result.word_kind   = r16pd_pkg::KIND_SINGLE;
				result.mnemonic_id = {3'b000, sop};
			end
		end else if (is_jump) begin
			result.word_kind   = r16pd_pkg::KIND_JUMP;
			result.mnemonic_id = r16pd_pkg::ID_JUMP0 + {3'b000, word[12:10]};
			result.jump_target = addr + jump_disp + 16'd2;
		end else if (is_double) begin
			result.source_register = word[11:8];
			result.dest_mode       = {1'b0, word[7]};
			result.byte_flag       = word[6];
			result.source_mode     = word[5:4];
			result.dest_register   = word[3:0];
			if (alias_hit) begin
				result.word_kind   = r16pd_pkg::KIND_ALIAS;
				result.mnemonic_id = r16pd_pkg::ID_ALIAS0 + {2'b00, alias_idx};
			end else begin
				s_ext = r16pd_pkg::ext_needed(word[11:8], word[5:4]);
				d_ext = r16pd_pkg::ext_needed(word[3:0], {1'b0, word[7]});
				result.word_kind       = r16pd_pkg::KIND_DOUBLE;
				result.mnemonic_id     = r16pd_pkg::double_id(word[15:12], word[11:8],
					word[5:4], word[3:0], word[7]);
				result.extension_count = {1'b0, s_ext} + {1'b0, d_ext};
				next_pending           = {1'b0, s_ext} + {1'b0, d_ext};
			end
		end
	end

endmodule

`default_nettype wire

// File: design/risc16_instruction_predecoder_core.sv
// Top level of the 16-bit instruction predecoder.
//
// Usage:
//   code   : valid/ready request channel, one code word per request with an
//            image_start flag that restarts at the base address and drops any
//            pending extension words before the word is decoded.
//   result : valid/ready request channel, one decode result per code word,
//            in order.
//   cfg_wr_en / cfg_wr_data : write the base address; write only while idle.
// Path: an accepted word passes through the input register, then the decode
//   logic, then the result register, before it appears on result.
// Throughput: one word per cycle while result.ready does not stall; the decode
//   of a word and the address and pending-extension update fit in one stage.
// Reset: clears both stages, sets the base and running address to 0xC000 and
//   the pending-extension count to zero.
// Stall: with result.ready low the result register holds, the input register
//   fills, and code.ready drops once both are full; nothing is lost.
`default_nettype none

module risc16_instruction_predecoder_core (
	input  wire logic         clk,
	input  wire logic         arst_n,
	r16pd_code_if.sink        code,
	r16pd_result_if.source    result,
	input  wire logic         cfg_wr_en,
	input  wire logic [15:0]  cfg_wr_data
);

	logic [15:0]          base_q;
	logic [15:0]          addr_q;
	logic [1:0]           pend_q;
	logic                 valid_s1;
	logic [15:0]          word_s1;
	logic                 start_s1;
	logic                 valid_s2;
	r16pd_pkg::result_t   res_s2;
	r16pd_pkg::result_t   dec_res;
	logic [1:0]           dec_pend;
	logic                 s2_free;
	logic                 advance;

	// Handshake: move stage 1 into stage 2 whenever stage 2 can take it
	assign s2_free    = !valid_s2 || result.ready;
	assign advance    = valid_s1 && s2_free;
	assign code.ready = !valid_s1 || advance;

	// Hold the base address
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= r16pd_pkg::BASE_RESET;
		end else if (cfg_wr_en) begin
			base_q <= cfg_wr_data;
		end
	end

	// Input stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (code.ready) begin
			valid_s1 <= code.valid;
		end
	end

	// Input stage payload
	always_ff @(posedge clk) begin
		if (code.ready && code.valid) begin
			word_s1  <= code.code_word;
			start_s1 <= code.image_start;
		end
	end

	r16pd_decode u_decode (
		.word         (word_s1),
		.image_start  (start_s1),
		.base_address (base_q),
		.cur_address  (addr_q),
		.cur_pending  (pend_q),
		.result       (dec_res),
		.next_pending (dec_pend)
	);

	// Advance the running address and pending count per decoded word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q <= r16pd_pkg::BASE_RESET;
			pend_q <= 2'd0;
		end else if (advance) begin
			addr_q <= dec_res.word_address + 16'd2;
			pend_q <= dec_pend;
		end
	end

	// Result stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= valid_s1;
		end
	end

	// Result stage payload
	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= dec_res;
		end
	end

	assign result.valid           = valid_s2;
	assign result.word_address    = res_s2.word_address;
	assign result.word_kind       = res_s2.word_kind;
	assign result.mnemonic_id     = res_s2.mnemonic_id;
	assign result.byte_flag       = res_s2.byte_flag;
	assign result.source_register = res_s2.source_register;
	assign result.source_mode     = res_s2.source_mode;
	assign result.dest_register   = res_s2.dest_register;
	assign result.dest_mode       = res_s2.dest_mode;
	assign result.extension_count = res_s2.extension_count;
	assign result.jump_target     = res_s2.jump_target;
	assign result.passed_word     = res_s2.passed_word;

endmodule

`default_nettype wire

// File: design/r16pd_checker.sv
// Port-level assertion checker for the predecoder and its bind.
`default_nettype none
`include "assert_macros.svh"

module r16pd_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        res_valid,
	input wire logic        res_ready,
	input wire logic [15:0] res_address,
	input wire logic [2:0]  res_kind,
	input wire logic [5:0]  res_id,
	input wire logic [1:0]  res_ext,
	input wire logic [15:0] res_target
);

	logic carries_ext;
	logic plain_word;

	assign carries_ext = (res_kind == r16pd_pkg::KIND_SINGLE)
		|| (res_kind == r16pd_pkg::KIND_DOUBLE) || (res_kind == r16pd_pkg::KIND_REJECT);
	assign plain_word = (res_kind == r16pd_pkg::KIND_ZERO)
		|| (res_kind == r16pd_pkg::KIND_DATA) || (res_kind == r16pd_pkg::KIND_EXT);

	// A stalled result holds
	`R16PD_ASSERT_NXT(a_res_hold, res_valid && !res_ready, res_valid && $stable({res_address, res_kind, res_id, res_ext, res_target}), "stalled result changed")

	// Jump target only on jumps
	`R16PD_ASSERT_IMP(a_target_jump, res_valid && (res_kind != r16pd_pkg::KIND_JUMP), res_target == 16'd0, "jump target on non-jump word")

	// Extension words only follow instructions with operands
	`R16PD_ASSERT_IMP(a_ext_kind, res_valid && (res_ext != 2'd0), carries_ext, "extension count on wrong kind")

	// Zero, data and extension words carry no mnemonic
	`R16PD_ASSERT_IMP(a_plain_id, res_valid && plain_word, (res_id == 6'd0) && (res_ext == 2'd0), "mnemonic on plain word")

endmodule

bind risc16_instruction_predecoder_core r16pd_checker u_r16pd_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.res_valid   (result.valid),
	.res_ready   (result.ready),
	.res_address (result.word_address),
	.res_kind    (result.word_kind),
	.res_id      (result.mnemonic_id),
	.res_ext     (result.extension_count),
	.res_target  (result.jump_target)
);

`default_nettype wire

// File: sim/risc16_instruction_predecoder_core_test.sv
// Self-checking testbench: predicts each decode result and checks it against the core.
`timescale 1ns / 100ps

module risc16_instruction_predecoder_core_test;

	localparam int unsigned CYCLE_LIMIT     = 200000;
	localparam int unsigned PIPE_DRAIN      = 6;
	localparam int unsigned PHASE_WORDS     = 120;
	localparam int unsigned HOLD_OFF_AT     = 200;
	localparam int unsigned HOLD_OFF_CYCLES = 80;

	// Opcode prefixes of the single-operand and jump groups
	localparam logic [5:0] SINGLE_PREFIX = 6'b000100;
	localparam logic [2:0] JUMP_PREFIX   = 3'b001;

	// Registers and addressing modes with special meaning
	localparam logic [3:0] REG_PC = 4'd0;
	localparam logic [3:0] REG_SP = 4'd1;
	localparam logic [3:0] REG_CG = 4'd3;
	localparam logic [1:0] MODE_REG      = 2'd0;
	localparam logic [1:0] MODE_INDEXED  = 2'd1;
	localparam logic [1:0] MODE_INDIRECT = 2'd2;
	localparam logic [1:0] MODE_AUTOINC  = 2'd3;

	typedef struct packed {
		logic [15:0] word;
		logic        start;
	} code_item_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_wr_en;
	logic [15:0] cfg_wr_data;

	r16pd_code_if   code_ch ();
	r16pd_result_if result_ch ();

	risc16_instruction_predecoder_core dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.code        (code_ch),
		.result      (result_ch),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	code_item_t           code_queue[$];
	r16pd_pkg::result_t   decode_expected[$];
	code_item_t           next_item;
	r16pd_pkg::result_t   want;
	logic [15:0] base_model = r16pd_pkg::BASE_RESET;
	logic [15:0] pc_model   = r16pd_pkg::BASE_RESET;
	logic [1:0]  ext_left   = 2'd0;
	int unsigned error_count  = 0;
	int unsigned cycle_count  = 0;
	int unsigned results_seen = 0;
	int unsigned burst_left;
	int unsigned gap_left;
	int unsigned hold_left;
	int unsigned stall_tick;
	logic        hold_done;
	logic [7:0]  stall_mask;

	// Extension words an operand needs
	function automatic logic [1:0] operand_words(input logic [3:0] rg, input logic [1:0] md);
		logic [1:0] n;
		if (rg == REG_CG)
			n = 2'd0;
		else if (rg == REG_PC)
			n = (md == MODE_INDEXED || md == MODE_AUTOINC) ? 2'd1 : 2'd0;
		else
			n = (md == MODE_INDEXED) ? 2'd1 : 2'd0;
		return n;
	endfunction

	// Mnemonic of a two-operand word, emulated forms first
	function automatic logic [5:0] two_operand_id(input logic [3:0] op, input logic [3:0] sr,
			input logic [1:0] sm, input logic [3:0] dr, input logic dm);
		logic       cg;
		logic       same;
		logic [5:0] id;
		cg   = (sr == REG_CG);
		same = (sr == dr) && (sm == {1'b0, dm});
		id   = r16pd_pkg::ID_DBL0 + {2'b00, op};
		if (op == r16pd_pkg::OP_MOV && sr == REG_SP && sm == MODE_AUTOINC)
			id = r16pd_pkg::ID_POP;
		else if (op == r16pd_pkg::OP_MOV && dr == REG_PC) id = r16pd_pkg::ID_BR;
		else if (op == r16pd_pkg::OP_ADD && cg && sm == MODE_INDEXED) id = r16pd_pkg::ID_INC;
		else if (op == r16pd_pkg::OP_ADD && cg && sm == MODE_INDIRECT) id = r16pd_pkg::ID_INCD;
		else if (op == r16pd_pkg::OP_ADD && !cg && same) id = r16pd_pkg::ID_RLA;
		else if (op == r16pd_pkg::OP_ADDC && cg && sm == MODE_REG) id = r16pd_pkg::ID_ADC;
		else if (op == r16pd_pkg::OP_ADDC && same) id = r16pd_pkg::ID_RLC;
		else if (op == r16pd_pkg::OP_SUBC && cg && sm == MODE_REG) id = r16pd_pkg::ID_SBC;
		else if (op == r16pd_pkg::OP_SUB && cg && sm == MODE_INDEXED) id = r16pd_pkg::ID_DEC;
		else if (op == r16pd_pkg::OP_SUB && cg && sm == MODE_INDIRECT) id = r16pd_pkg::ID_DECD;
		else if (op == r16pd_pkg::OP_CMP && cg && sm == MODE_REG) id = r16pd_pkg::ID_TST;
		else if (op == r16pd_pkg::OP_DADD && cg && sm == MODE_REG) id = r16pd_pkg::ID_DADC;
		else if (op == r16pd_pkg::OP_XOR && cg && sm == MODE_AUTOINC) id = r16pd_pkg::ID_INV;
		return id;
	endfunction

	// Decode a word that stands where an instruction is due
	function automatic r16pd_pkg::result_t classify_word(input logic [15:0] w,
			input logic [15:0] addr);
		r16pd_pkg::result_t r;
		logic [2:0]         sop;
		int                 k;
		r = '0;
		r.word_address = addr;
		r.passed_word  = w;
		r.word_kind    = r16pd_pkg::KIND_DATA;
		sop = w[9:7];
		if (w == 16'h0000) begin
			r.word_kind = r16pd_pkg::KIND_ZERO;
		end else if (w[15:10] == SINGLE_PREFIX) begin
			r.byte_flag       = w[6];
			r.dest_mode       = w[5:4];
			r.dest_register   = w[3:0];
			r.extension_count = operand_words(w[3:0], w[5:4]);
			if (sop == r16pd_pkg::SOP_INVALID
					|| (w[6] && (sop[0] || sop == r16pd_pkg::SOP_RETI))) begin
				r.word_kind = r16pd_pkg::KIND_REJECT;
			end else begin
				r.word_kind   = r16pd_pkg::KIND_SINGLE;
				r.mnemonic_id = {3'b000, sop};
			end
		end else if (w[15:13] == JUMP_PREFIX) begin
			r.word_kind   = r16pd_pkg::KIND_JUMP;
			r.mnemonic_id = r16pd_pkg::ID_JUMP0 + {3'b000, w[12:10]};
			r.jump_target = addr + {{5{w[9]}}, w[9:0], 1'b0} + 16'd2;
		end else if (w[15:14] != 2'b00) begin
			r.source_register = w[11:8];
			r.dest_mode       = {1'b0, w[7]};
			r.byte_flag       = w[6];
			r.source_mode     = w[5:4];
			r.dest_register   = w[3:0];
			r.word_kind       = r16pd_pkg::KIND_DOUBLE;
			for (k = 0; k < r16pd_pkg::ALIAS_COUNT; k++) begin
				if (r16pd_pkg::ALIAS_WORDS[k] == w) begin
					r.word_kind   = r16pd_pkg::KIND_ALIAS;
					r.mnemonic_id = r16pd_pkg::ID_ALIAS0 + k[5:0];
				end
			end
			if (r.word_kind == r16pd_pkg::KIND_DOUBLE) begin
				r.extension_count = operand_words(w[11:8], w[5:4]) +
					operand_words(w[3:0], {1'b0, w[7]});
				r.mnemonic_id = two_operand_id(w[15:12], w[11:8], w[5:4], w[3:0], w[7]);
			end
		end
		return r;
	endfunction

	// Advance the address and extension tracking by one accepted word
	function automatic r16pd_pkg::result_t predict_decode(input logic [15:0] w,
			input logic start);
		r16pd_pkg::result_t r;
		if (start) begin
			pc_model = base_model;
			ext_left = 2'd0;
		end
		if (ext_left != 2'd0) begin
			r = '0;
			r.word_address = pc_model;
			r.word_kind    = r16pd_pkg::KIND_EXT;
			r.passed_word  = w;
			ext_left = ext_left - 2'd1;
		end else begin
			r = classify_word(w, pc_model);
			ext_left = r.extension_count;
		end
		pc_model = pc_model + 16'd2;
		return r;
	endfunction

	task automatic report_error(input string what, input logic [15:0] got,
			input logic [15:0] exp_val);
		$display("ERROR %s: got %h, want %h", what, got, exp_val);
		error_count++;
	endtask

	task automatic check_field(input string name, input logic [15:0] got,
			input logic [15:0] exp_val, input logic [15:0] addr);
		if (got !== exp_val)
			report_error($sformatf("word at %h, %s", addr, name), got, exp_val);
	endtask

	task automatic queue_word(input logic [15:0] w, input logic start);
		code_queue.push_back(code_item_t'{w, start});
	endtask

	// Queue one instruction of a random class followed by its extension words, at times one short
	task automatic queue_random_instruction(input logic force_start, inout int unsigned pushed);
		logic [15:0]        w;
		logic [3:0]         sr;
		logic [3:0]         dr;
		logic [1:0]         sm;
		logic               dm;
		int unsigned        sel;
		int unsigned        n_ext;
		int unsigned        k;
		r16pd_pkg::result_t probe;
		sel = $urandom_range(0, 99);
		w = 16'($urandom);
		if (sel < 20) begin
			w[15:10] = SINGLE_PREFIX;
		end else if (sel < 32) begin
			w[15:13] = JUMP_PREFIX;
		end else if (sel < 68) begin
			// lean on the constant generator and equal operands to hit emulated forms
			sr = ($urandom_range(0, 2) == 0) ? REG_CG : 4'($urandom);
			dr = 4'($urandom);
			sm = 2'($urandom);
			dm = 1'($urandom);
			if ($urandom_range(0, 3) == 0) begin
				dr = sr;
				sm = {1'b0, dm};
			end
			w = {4'($urandom_range(4, 15)), sr, dm, 1'($urandom), sm, dr};
		end else if (sel < 76) begin
			w = r16pd_pkg::ALIAS_WORDS[$urandom_range(0, r16pd_pkg::ALIAS_COUNT - 1)];
		end else if (sel < 80) begin
			w = 16'h0000;
		end else if (sel < 90) begin
			w[15:14] = 2'b00;
		end
		probe = classify_word(w, 16'h0000);
		n_ext = {30'd0, probe.extension_count};
		// cut a few sequences short
		if (n_ext != 0 && $urandom_range(0, 9) == 0)
			n_ext--;
		queue_word(w, force_start || ($urandom_range(0, 29) == 0));
		pushed++;
		for (k = 0; k < n_ext; k++) begin
			queue_word(16'($urandom), $urandom_range(0, 39) == 0);
			pushed++;
		end
	endtask

	task automatic wait_idle();
		while (code_queue.size() != 0 || code_ch.valid || decode_expected.size() != 0)
			@(posedge clk);
		repeat (PIPE_DRAIN) @(posedge clk);
	endtask

	task automatic write_base(input logic [15:0] value);
		@(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en  <= 1'b0;
		base_model = value;
	endtask

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// Sender: offer queued requests in bursts separated by random gaps
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			code_ch.valid       <= 1'b0;
			code_ch.code_word   <= 16'h0000;
			code_ch.image_start <= 1'b0;
			burst_left <= 0;
			gap_left   <= 0;
		end else begin
			if (code_ch.valid && code_ch.ready)
				decode_expected.push_back(predict_decode(code_ch.code_word, code_ch.image_start));
			if (!code_ch.valid || code_ch.ready) begin
				if (gap_left != 0) begin
					gap_left      <= gap_left - 1;
					code_ch.valid <= 1'b0;
				end else if (code_queue.size() != 0) begin
					next_item = code_queue.pop_front();
					code_ch.valid       <= 1'b1;
					code_ch.code_word   <= next_item.word;
					code_ch.image_start <= next_item.start;
					if (burst_left <= 1) begin
						burst_left <= $urandom_range(1, 16);
						gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
					end else begin
						burst_left <= burst_left - 1;
					end
				end else begin
					code_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: check each result against the oldest prediction, stall on a rotating mask
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
			stall_mask <= 8'hFF;
			stall_tick <= 0;
			hold_left  <= 0;
			hold_done  <= 1'b0;
		end else begin
			if (result_ch.valid && result_ch.ready) begin
				if (decode_expected.size() == 0) begin
					report_error("result with nothing expected", result_ch.word_address, 16'h0000);
				end else begin
					want = decode_expected.pop_front();
					check_field("word_address", result_ch.word_address, want.word_address,
						want.word_address);
					check_field("word_kind", 16'(result_ch.word_kind), 16'(want.word_kind),
						want.word_address);
					check_field("mnemonic_id", 16'(result_ch.mnemonic_id), 16'(want.mnemonic_id),
						want.word_address);
					check_field("byte_flag", 16'(result_ch.byte_flag), 16'(want.byte_flag),
						want.word_address);
					check_field("source_register", 16'(result_ch.source_register),
						16'(want.source_register), want.word_address);
					check_field("source_mode", 16'(result_ch.source_mode), 16'(want.source_mode),
						want.word_address);
					check_field("dest_register", 16'(result_ch.dest_register),
						16'(want.dest_register), want.word_address);
					check_field("dest_mode", 16'(result_ch.dest_mode), 16'(want.dest_mode),
						want.word_address);
					check_field("extension_count", 16'(result_ch.extension_count),
						16'(want.extension_count), want.word_address);
					check_field("jump_target", result_ch.jump_target, want.jump_target,
						want.word_address);
					check_field("passed_word", result_ch.passed_word, want.passed_word,
						want.word_address);
				end
				results_seen++;
			end
			// hold off once for a long stretch so the core fills and stalls its input
			if (!hold_done && results_seen >= HOLD_OFF_AT) begin
				hold_done       <= 1'b1;
				hold_left       <= HOLD_OFF_CYCLES;
				result_ch.ready <= 1'b0;
			end else if (hold_left != 0) begin
				hold_left       <= hold_left - 1;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= stall_mask[0];
				stall_tick      <= stall_tick + 1;
				if (stall_tick % 64 == 63) begin
					case ($urandom_range(0, 3))
						0: stall_mask <= 8'hFF;
						1: stall_mask <= 8'h11;
						default: stall_mask <= 8'($urandom) | 8'h01;
					endcase
				end else begin
					stall_mask <= {stall_mask[0], stall_mask[7:1]};
				end
			end
		end
	end

	initial begin
		int unsigned pushed;
		int          phase;
		logic        first;
		logic [15:0] base_values [5];
		arst_n      = 1'b0;
		cfg_wr_en   = 1'b0;
		cfg_wr_data = 16'h0000;
		base_values = '{16'hFFFE, 16'h0000, 16'hFFFF, 16'($urandom), 16'h8000};
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Directed words at the reset base address
		queue_word(16'h0000, 1'b1);   // zero word, restart
		queue_word(16'hFFFF, 1'b0);   // and.b with an indexed destination
		queue_word(16'hFFFF, 1'b0);   // its extension
		queue_word(16'h4303, 1'b0);   // nop
		queue_word(16'h4130, 1'b0);   // ret
		queue_word(16'hC232, 1'b0);   // dint
		queue_word(16'h12B0, 1'b0);   // call with an immediate
		queue_word(16'h1234, 1'b0);
		queue_word(16'h1395, 1'b0);   // invalid single opcode, indexed operand still consumed
		queue_word(16'h0000, 1'b0);   // extension that looks like a zero word
		queue_word(16'h10C4, 1'b0);   // swpb.b rejected
		queue_word(16'h1340, 1'b0);   // reti.b rejected
		queue_word(16'h3DFF, 1'b0);   // jmp, furthest forward
		queue_word(16'h2200, 1'b0);   // jnz, furthest back
		queue_word(16'h27FF, 1'b0);   // jz to itself
		queue_word(16'h4295, 1'b0);   // mov with two extension words
		queue_word(16'hAAAA, 1'b0);
		queue_word(16'h5555, 1'b0);
		queue_word(16'h5090, 1'b0);   // add with two extension words
		queue_word(16'h1111, 1'b0);
		queue_word(16'h3FFF, 1'b1);   // restart drops the second extension
		queue_word(16'h0FFF, 1'b0);   // data
		queue_word(16'hE33F, 1'b0);   // inv
		queue_word(16'h6305, 1'b0);   // adc
		queue_word(16'h4030, 1'b0);   // br with an immediate
		queue_word(16'hFFFF, 1'b0);
		wait_idle();

		// Random phases under several base addresses; one phase starts without a forced restart
		for (phase = 0; phase < 5; phase++) begin
			write_base(base_values[phase]);
			pushed = 0;
			first  = (phase != 2);
			while (pushed < PHASE_WORDS) begin
				queue_random_instruction(first, pushed);
				first = 1'b0;
			end
			wait_idle();
		end

		if (error_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

// File: filelist.f
+incdir+design
design/r16pd_pkg.sv
design/r16pd_if.sv
design/r16pd_decode.sv
design/risc16_instruction_predecoder_core.sv
design/r16pd_checker.sv
sim/risc16_instruction_predecoder_core_test.sv
